// ===== sv/ble_fragment_reassembler_core_assert.svh =====
// Assertion macros for the fragment reassembler core.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef BLE_FRAGMENT_REASSEMBLER_CORE_ASSERT_SVH
`define BLE_FRAGMENT_REASSEMBLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define BFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define BFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ble_fr_pkg.sv =====
// Shared widths, register indexes and status codes for the fragment reassembler.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package ble_fr_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int MTU_W    = 10;
    localparam int COUNT_W  = 17;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MTU_SIZE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_COMMAND = 1'b1;

    localparam logic [MTU_W-1:0]   MTU_RESET  = 10'd20;
    localparam logic [BYTE_W-1:0]  PING_RESET = 8'd129;
    localparam int                 MTU_MIN    = 4;
    localparam int                 HDR_BYTES  = 3;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 17'h1FFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_LEN_MISMATCH = 2'd1,
        ST_SEQ_ERROR    = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ===== sv/ble_fr_if.sv =====
// Valid/ready channel interfaces for raw input words and reassembled result words.
// Depends on ble_fr_pkg for field widths.
`default_nettype none

interface ble_fr_in_if;
    logic                          valid;
    logic                          ready;
    logic [ble_fr_pkg::BYTE_W-1:0] data_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ble_fr_out_if;
    logic                            valid;
    logic                            ready;
    logic [ble_fr_pkg::BYTE_W-1:0]   out_byte;
    logic                            is_status;
    logic [ble_fr_pkg::STATUS_W-1:0] status;
    logic [ble_fr_pkg::LEN_W-1:0]    payload_length;
    logic                            last;

    modport source (output valid, output out_byte, output is_status, output status,
                    output payload_length, output last, input ready);
    modport sink   (input valid, input out_byte, input is_status, input status,
                    input payload_length, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/ble_fragment_reassembler_core.sv =====
// Fragment reassembler: raw frame bytes in, payload bytes and an end status out.
// Depends on ble_fr_pkg, ble_fr_if.sv and ble_fragment_reassembler_core_assert.svh.
//
// Use:
//   i_in  carries one raw received byte per word plus last_byte on the final
//         byte of the message. o_out carries payload bytes and, after the
//         final byte, one status word (is_status=1, last=1) with the declared
//         length. Configuration (mtu_size, ping_command) must be written
//         through i_cfg_we / i_cfg_idx / i_cfg_data while no message is in
//         flight; the core itself does not enforce this.
//   Each accepted byte updates the frame and message counters and yields
//   zero to four result words, packed as one bundle into a registered
//   two-entry result queue. While o_out.ready is high the queue drains one
//   word per cycle, so a stream of single-result bytes runs at one byte per
//   cycle; a ping header (three bytes at once) or a status word adds words.
//   i_in.ready is high while the queue has a free bundle slot, so a new byte
//   is taken even while a result waits at the output. If the receiver stalls,
//   the queue fills and ready drops after at most two bundles.
//   Reset (synchronous, active low) clears all message state and the queue,
//   and loads mtu_size=20, ping_command=129.
`default_nettype none

`include "ble_fragment_reassembler_core_assert.svh"

module ble_fragment_reassembler_core #(
    parameter int MAX_FRAME_BYTES = 512
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [ble_fr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [ble_fr_pkg::CFG_W-1:0]         i_cfg_data,
    ble_fr_in_if.sink                           i_in,
    ble_fr_out_if.source                        o_out
);

    localparam int FP_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int EW   = (FP_W > ble_fr_pkg::MTU_W) ? FP_W : ble_fr_pkg::MTU_W;
    localparam int BW   = ble_fr_pkg::BYTE_W;
    localparam int LW   = ble_fr_pkg::LEN_W;
    localparam int CW   = ble_fr_pkg::COUNT_W;

    typedef struct packed {
        logic [2:0][BW-1:0]        bytes;
        logic [1:0]                nbytes;
        logic                      has_status;
        ble_fr_pkg::t_status       status;
        logic [LW-1:0]             plen;
    } t_bundle;

    // Configuration registers
    logic [ble_fr_pkg::MTU_W-1:0] r_mtu;
    logic [BW-1:0]                r_ping;

    // Message state
    logic [FP_W-1:0] r_fpos,   n_fpos;
    logic            r_cont,   n_cont;
    logic [BW-1:0]   r_exp,    n_exp;
    logic            r_fault,  n_fault;
    logic [CW-1:0]   r_cc,     n_cc;
    logic [BW-1:0]   r_cmd,    n_cmd;
    logic [BW-1:0]   r_lenh,   n_lenh;
    logic [LW-1:0]   r_decl,   n_decl;
    logic [LW-1:0]   r_emit,   n_emit;

    // Result queue
    t_bundle         r_q [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    logic [1:0]      r_sub;

    t_bundle         n_bundle;
    logic            in_acc;
    logic            push;
    logic            pop;
    logic            out_acc;
    logic            bundle_done;
    logic            is_byte;
    t_bundle         head;
    logic [EW-1:0]   mtu_ext;
    logic [FP_W-1:0] eff_mtu;
    logic [FP_W-1:0] fp_inc;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    // Clamp frame size to [MTU_MIN, MAX_FRAME_BYTES]
    always_comb begin
        mtu_ext = EW'(r_mtu);
        if (mtu_ext < EW'(ble_fr_pkg::MTU_MIN)) begin
            mtu_ext = EW'(ble_fr_pkg::MTU_MIN);
        end else if (mtu_ext > EW'(MAX_FRAME_BYTES)) begin
            mtu_ext = EW'(MAX_FRAME_BYTES);
        end
        eff_mtu = FP_W'(mtu_ext);
    end

    assign fp_inc = r_fpos + FP_W'(1);

    // Per-word state update and result bundle
    always_comb begin
        logic            ping;
        logic [LW-1:0]   decl_new;
        logic [CW-1:0]   need;

        n_fpos  = r_fpos;
        n_cont  = r_cont;
        n_exp   = r_exp;
        n_fault = r_fault;
        n_cc    = r_cc;
        n_cmd   = r_cmd;
        n_lenh  = r_lenh;
        n_decl  = r_decl;
        n_emit  = r_emit;

        n_bundle            = '0;
        n_bundle.status     = ble_fr_pkg::ST_OK;

        ping     = (r_cmd == r_ping);
        decl_new = {r_lenh, i_in.data_byte};

        if (r_cont && (r_fpos == '0)) begin
            // sequence byte: check and drop
            if (i_in.data_byte != r_exp) begin
                n_fault = 1'b1;
            end
            n_exp = r_exp + BW'(1);
        end else begin
            if (r_cc != ble_fr_pkg::COUNT_MAX) begin
                n_cc = r_cc + CW'(1);
            end
            if (r_cc == CW'(0)) begin
                n_cmd = i_in.data_byte;
            end else if (r_cc == CW'(1)) begin
                n_lenh = i_in.data_byte;
            end else if (r_cc == CW'(2)) begin
                n_decl = decl_new;
                if (ping) begin
                    n_bundle.bytes[0] = r_cmd;
                    n_bundle.bytes[1] = r_lenh;
                    n_bundle.bytes[2] = i_in.data_byte;
                    n_bundle.nbytes   = (decl_new < LW'(ble_fr_pkg::HDR_BYTES)) ?
                                        decl_new[1:0] : 2'(ble_fr_pkg::HDR_BYTES);
                    n_emit            = LW'(n_bundle.nbytes);
                end
            end else if (r_emit < r_decl) begin
                n_bundle.bytes[0] = i_in.data_byte;
                n_bundle.nbytes   = 2'd1;
                n_emit            = r_emit + LW'(1);
            end
        end

        if (fp_inc >= eff_mtu) begin
            n_fpos = '0;
            n_cont = 1'b1;
        end else begin
            n_fpos = fp_inc;
        end

        need = CW'(n_decl) + CW'(ble_fr_pkg::HDR_BYTES);
        if (i_in.last_byte) begin
            n_bundle.has_status = 1'b1;
            n_bundle.plen       = n_decl;
            if (n_cc != need) begin
                n_bundle.status = ble_fr_pkg::ST_LEN_MISMATCH;
            end else if (n_fault) begin
                n_bundle.status = ble_fr_pkg::ST_SEQ_ERROR;
            end
            // end of message: drop all message state
            n_fpos  = '0;
            n_cont  = 1'b0;
            n_exp   = '0;
            n_fault = 1'b0;
            n_cc    = '0;
            n_cmd   = '0;
            n_lenh  = '0;
            n_decl  = '0;
            n_emit  = '0;
        end
    end

    assign push = in_acc && ((n_bundle.nbytes != 2'd0) || n_bundle.has_status);

    // Output side: unwind the head bundle one word at a time
    assign head        = r_q[r_rd];
    assign is_byte     = (r_sub < head.nbytes);
    assign bundle_done = head.has_status ? (r_sub == head.nbytes)
                                         : (r_sub == (head.nbytes - 2'd1));
    assign pop         = out_acc && bundle_done;

    assign i_in.ready           = (r_cnt != 2'd2);
    assign o_out.valid          = (r_cnt != 2'd0);
    assign o_out.out_byte       = is_byte ? head.bytes[r_sub] : '0;
    assign o_out.is_status      = !is_byte;
    assign o_out.status         = is_byte ? ble_fr_pkg::STATUS_W'(ble_fr_pkg::ST_OK)
                                          : ble_fr_pkg::STATUS_W'(head.status);
    assign o_out.payload_length = is_byte ? '0 : head.plen;
    assign o_out.last           = !is_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu   <= ble_fr_pkg::MTU_RESET;
            r_ping  <= ble_fr_pkg::PING_RESET;
            r_fpos  <= '0;
            r_cont  <= 1'b0;
            r_exp   <= '0;
            r_fault <= 1'b0;
            r_cc    <= '0;
            r_cmd   <= '0;
            r_lenh  <= '0;
            r_decl  <= '0;
            r_emit  <= '0;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_cnt   <= '0;
            r_sub   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ble_fr_pkg::CFG_MTU_SIZE: begin
                        r_mtu <= i_cfg_data[ble_fr_pkg::MTU_W-1:0];
                    end
                    ble_fr_pkg::CFG_PING_COMMAND: begin
                        r_ping <= i_cfg_data[BW-1:0];
                    end
                    default: begin
                        r_mtu <= r_mtu;
                    end
                endcase
            end
            if (in_acc) begin
                r_fpos  <= n_fpos;
                r_cont  <= n_cont;
                r_exp   <= n_exp;
                r_fault <= n_fault;
                r_cc    <= n_cc;
                r_cmd   <= n_cmd;
                r_lenh  <= n_lenh;
                r_decl  <= n_decl;
                r_emit  <= n_emit;
            end
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (out_acc) begin
                r_sub <= bundle_done ? 2'd0 : (r_sub + 2'd1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Queue payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_bundle;
        end
    end

    `BFR_ASSERT_NEXT(a_clear_on_last, i_clk, i_rst_n, in_acc && i_in.last_byte, (r_cc == '0) && (r_fpos == '0) && !r_cont && !r_fault, "message state not cleared after last byte")
    `BFR_ASSERT_NOW(a_fpos_bound, i_clk, i_rst_n, 1'b1, r_fpos < FP_W'(MAX_FRAME_BYTES), "frame position beyond maximum frame size")
    `BFR_ASSERT_NOW(a_emit_bound, i_clk, i_rst_n, 1'b1, r_emit <= r_decl, "more payload bytes emitted than declared")
    `BFR_ASSERT_NOW(a_fault_in_cont, i_clk, i_rst_n, $rose(r_fault), $past(r_cont), "sequence fault raised outside a continuation frame")

endmodule

`default_nettype wire
